// ===== design/rcnl_pkg.sv =====
// Shared types and constants for the reference curve nearest lookup block.
// Used by every module under design/ except rcnl_ram, and by the bench; depends on nothing else.

package rcnl_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int DATA_W      = 32;
    localparam int POS_SUM_W   = DATA_W + 1;
    localparam int ENTRY_W     = 2 * DATA_W;

    // fixed field widths of the stream payload and the APB address
    localparam int MODE_W      = 2;
    localparam int IN_INDEX_W  = 10;
    localparam int IN_COUNT_W  = 11;
    localparam int S_TDATA_W   = 120;
    localparam int M_TDATA_W   = 32;
    localparam int APB_ADDR_W  = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD       = 2'd0,
        MODE_SEAM_START = 2'd1,
        MODE_SEAM_END   = 2'd2,
        MODE_SAMPLE     = 2'd3
    } mode_t;

    localparam logic REG_POSITION_OFFSET = 1'b0;
    localparam logic REG_VALUE_OFFSET    = 1'b1;

    typedef struct packed {
        logic [DATA_W-1:0] position_offset;
        logic [DATA_W-1:0] value_offset;
    } rcnl_cfg_t;

    typedef struct packed {
        mode_t                 mode;
        logic [IN_INDEX_W-1:0] entry_index;
        logic [DATA_W-1:0]     entry_position;
        logic [DATA_W-1:0]     entry_value;
        logic [IN_COUNT_W-1:0] entry_count;
        logic [DATA_W-1:0]     frame_position;
    } rcnl_in_t;

    typedef struct packed {
        logic [DATA_W-1:0] ref_value;
        logic              rank_max;
    } rcnl_out_t;

endpackage

// ===== design/rcnl_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.

module rcnl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/rcnl_regs.sv =====
// APB configuration registers: position offset and value offset.
// Depends on rcnl_pkg.

module rcnl_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rcnl_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rcnl_pkg::DATA_W-1:0]     pwdata,
    output logic [rcnl_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,
    output rcnl_pkg::rcnl_cfg_t            cfg
);

    import rcnl_pkg::*;

    logic [DATA_W-1:0] pos_off_reg;
    logic [DATA_W-1:0] val_off_reg;
    logic              reg_index;
    logic              wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign wr_en     = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_off_reg <= '0;
            val_off_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_index)
                REG_POSITION_OFFSET: pos_off_reg <= pwdata;
                REG_VALUE_OFFSET:    val_off_reg <= pwdata;
                default:             pos_off_reg <= pos_off_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            REG_POSITION_OFFSET: prdata = pos_off_reg;
            REG_VALUE_OFFSET:    prdata = val_off_reg;
            default:             prdata = '0;
        endcase
    end

    assign cfg.position_offset = pos_off_reg;
    assign cfg.value_offset    = val_off_reg;

endmodule

// ===== design/rcnl_walker.sv =====
// Table memory, cursor state and lookup sequencer with output register.
// Depends on rcnl_pkg and rcnl_ram.

module rcnl_walker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  rcnl_pkg::rcnl_in_t  in_item,
    input  rcnl_pkg::rcnl_cfg_t cfg,
    output logic                out_valid,
    input  logic                out_ready,
    output rcnl_pkg::rcnl_out_t out_item
);

    import rcnl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREV,
        S_WALK,
        S_OUT
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 armed_reg;
    logic [CNT_W-1:0]     cursor_reg;
    logic [IDX_W-1:0]     prev_reg;
    logic [DATA_W-1:0]    prev_pos_reg;
    logic [DATA_W-1:0]    prev_val_reg;
    logic [POS_SUM_W-1:0] pos_reg;
    logic [DATA_W-1:0]    val_reg;
    logic                 rank_reg;
    logic                 out_valid_reg;
    logic [DATA_W-1:0]    out_value_reg;
    logic                 out_rank_reg;

    logic                 accept;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [DATA_W-1:0]    rd_pos;
    logic [DATA_W-1:0]    rd_val;
    logic [POS_SUM_W-1:0] pos_sum;
    logic [POS_SUM_W-1:0] rd_pos_ext;
    logic                 restart;
    logic                 cur_above;
    logic [POS_SUM_W:0]   twice_pos;
    logic [POS_SUM_W:0]   pair_sum;
    logic                 prev_nearer;
    logic [CNT_W-1:0]     cursor_inc;
    logic [CNT_W-1:0]     count_sat;
    logic [POS_SUM_W-1:0] out_sum;
    logic [DATA_W-1:0]    out_sat;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    assign ram_we = accept && (in_item.mode == MODE_LOAD)
                    && (32'(in_item.entry_index) < TABLE_DEPTH);

    always_comb begin
        unique case (state_reg)
            S_IDLE:  ram_raddr = prev_reg;
            S_PREV:  ram_raddr = restart ? '0 : cursor_reg[IDX_W-1:0];
            S_WALK:  ram_raddr = cursor_inc[IDX_W-1:0];
            default: ram_raddr = prev_reg;
        endcase
    end

    rcnl_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(IDX_W'(in_item.entry_index)),
        .wdata({in_item.entry_position, in_item.entry_value}),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_pos = ram_rdata[ENTRY_W-1:DATA_W];
    assign rd_val = ram_rdata[DATA_W-1:0];

    assign pos_sum    = {in_item.frame_position[DATA_W-1], in_item.frame_position}
                      + {cfg.position_offset[DATA_W-1], cfg.position_offset};
    assign rd_pos_ext = {rd_pos[DATA_W-1], rd_pos};
    assign restart    = $signed(pos_reg) < $signed(rd_pos_ext);
    assign cur_above  = $signed(rd_pos_ext) > $signed(pos_reg);

    // prev <= pos < cur, so prev is nearer iff 2*pos < cur + prev
    assign twice_pos   = {pos_reg, 1'b0};
    assign pair_sum    = {{2{rd_pos[DATA_W-1]}}, rd_pos}
                       + {{2{prev_pos_reg[DATA_W-1]}}, prev_pos_reg};
    assign prev_nearer = $signed(twice_pos) < $signed(pair_sum);

    assign cursor_inc = cursor_reg + CNT_W'(1);
    assign count_sat  = (32'(in_item.entry_count) > TABLE_DEPTH)
                      ? CNT_W'(TABLE_DEPTH) : CNT_W'(in_item.entry_count);

    assign out_sum = {val_reg[DATA_W-1], val_reg}
                   + {cfg.value_offset[DATA_W-1], cfg.value_offset};
    always_comb begin
        if (out_sum[POS_SUM_W-1] != out_sum[DATA_W-1]) begin
            out_sat = out_sum[POS_SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                           : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            out_sat = out_sum[DATA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            armed_reg     <= 1'b0;
            cursor_reg    <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (state_reg == S_OUT && (!out_valid_reg || out_ready)) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        unique case (in_item.mode)
                            MODE_LOAD: begin
                                count_reg <= count_reg;
                            end
                            MODE_SEAM_START: begin
                                count_reg  <= count_sat;
                                armed_reg  <= (count_sat != '0);
                                cursor_reg <= '0;
                                prev_reg   <= '0;
                            end
                            MODE_SEAM_END: begin
                                armed_reg <= 1'b0;
                            end
                            MODE_SAMPLE: begin
                                pos_reg <= pos_sum;
                                if (armed_reg) begin
                                    state_reg <= S_PREV;
                                end else begin
                                    rank_reg  <= 1'b0;
                                    state_reg <= S_OUT;
                                end
                            end
                            default: begin
                                count_reg <= count_reg;
                            end
                        endcase
                    end
                end
                S_PREV: begin
                    // memory holds the entry at the previous index
                    if (restart) begin
                        cursor_reg <= '0;
                        prev_reg   <= '0;
                        state_reg  <= S_WALK;
                    end else begin
                        prev_pos_reg <= rd_pos;
                        prev_val_reg <= rd_val;
                        if (cursor_reg == count_reg) begin
                            // past the end: previous index is the last entry
                            val_reg   <= rd_val;
                            rank_reg  <= 1'b1;
                            state_reg <= S_OUT;
                        end else begin
                            state_reg <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    // memory holds the entry at the cursor; next one is already read
                    if (cur_above) begin
                        val_reg <= (cursor_reg != CNT_W'(prev_reg) && prev_nearer)
                                 ? prev_val_reg : rd_val;
                        rank_reg  <= 1'b1;
                        state_reg <= S_OUT;
                    end else begin
                        prev_reg     <= cursor_reg[IDX_W-1:0];
                        prev_pos_reg <= rd_pos;
                        prev_val_reg <= rd_val;
                        cursor_reg   <= cursor_inc;
                        if (cursor_inc == count_reg) begin
                            val_reg   <= rd_val;
                            rank_reg  <= 1'b1;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (!out_valid_reg || out_ready) begin
                        out_value_reg <= rank_reg ? out_sat : '0;
                        out_rank_reg  <= rank_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_item.ref_value = out_value_reg;
    assign out_item.rank_max  = out_rank_reg;

    a_prev_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        armed_reg |-> (CNT_W'(prev_reg) < count_reg))
        else $error("previous index beyond armed entry count");

    a_cursor_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        armed_reg |-> (cursor_reg <= count_reg))
        else $error("cursor beyond armed entry count");

    a_walk_below_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK) |-> (cursor_reg < count_reg) && armed_reg)
        else $error("walk step at or past the end of the curve");

    a_no_curve_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_rank_reg) |-> (out_value_reg == '0))
        else $error("nonzero value reported without a curve");

endmodule

// ===== design/reference_curve_nearest_lookup_top.sv =====
// Top level: stream and APB ports, payload packing, register file and walker.
// Depends on rcnl_pkg, rcnl_regs, rcnl_walker (and rcnl_ram below it).
// Load, seam start and seam end transactions are accepted back to back. A sample
// passes S_PREV (entry at the previous index read), then S_WALK as needed (cursor
// examines one entry per cycle; a backward jump rewalks from entry 0), then S_OUT,
// or goes right to S_OUT with no curve armed. S_OUT waits while an earlier result
// is unaccepted; s_tready returns in the cycle after the result is registered there.
// Reset is synchronous on aresetn: control state and offsets clear, table
// contents stay undefined until loaded.

module reference_curve_nearest_lookup_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // entry_index, entry_position, entry_value, entry_count, frame_position, pad
    input  logic [rcnl_pkg::S_TDATA_W-1:0]   s_tdata,
    // mode
    input  logic [rcnl_pkg::MODE_W-1:0]      s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // ref_value
    output logic [rcnl_pkg::M_TDATA_W-1:0]   m_tdata,
    // rank_max
    output logic [0:0]                       m_tuser,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rcnl_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rcnl_pkg::DATA_W-1:0]      pwdata,
    output logic [rcnl_pkg::DATA_W-1:0]      prdata,
    output logic                             pready
);

    import rcnl_pkg::*;

    rcnl_cfg_t cfg;
    rcnl_in_t  in_item;
    rcnl_out_t out_item;

    assign in_item.mode           = mode_t'(s_tuser);
    assign in_item.entry_index    = s_tdata[9:0];
    assign in_item.entry_position = s_tdata[41:10];
    assign in_item.entry_value    = s_tdata[73:42];
    assign in_item.entry_count    = s_tdata[84:74];
    assign in_item.frame_position = s_tdata[116:85];

    rcnl_regs u_regs (
        .aclk   (aclk),
        .aresetn(aresetn),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .cfg    (cfg)
    );

    rcnl_walker u_walker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .cfg      (cfg),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_item (out_item)
    );

    assign m_tdata    = out_item.ref_value;
    assign m_tuser[0] = out_item.rank_max;

endmodule

// ===== bench/reference_curve_nearest_lookup_top_tb.sv =====
// Self-checking bench for reference_curve_nearest_lookup_top: stream driver, APB writes,
// and a transaction-level predictor of the nearest-entry lookup with a forward-only cursor.
// Depends on rcnl_pkg and the design under design/.

module reference_curve_nearest_lookup_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rcnl_pkg::*;

    localparam longint P_MAX       = 64'sd2147483647;
    localparam longint P_MIN       = -64'sd2147483648;
    localparam int     CYCLE_LIMIT = 2_000_000;
    localparam int     ITEM_TARGET = 1950;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic [MODE_W-1:0]     s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [0:0]            m_tuser;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [DATA_W-1:0]     pwdata   = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    reference_curve_nearest_lookup_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // predictor copy of table, cursor and offsets
    logic signed [31:0] tbl_pos [TABLE_DEPTH];
    logic signed [31:0] tbl_val [TABLE_DEPTH];
    int                 armed_count = 0;
    int                 cursor_idx  = 0;
    int                 prev_idx    = 0;
    bit                 curve_live  = 1'b0;
    logic signed [31:0] pos_offset  = '0;
    logic signed [31:0] val_offset  = '0;

    rcnl_in_t  stream_items [$];
    rcnl_out_t lookup_results_due [$];
    rcnl_in_t  cur_item;
    int        accept_count  = 0;
    int        seen_count    = 0;
    int        item_total    = 0;
    int        mismatch_count = 0;
    int        cycle_count   = 0;

    // stimulus-side view of the current curve, used to aim samples
    longint gen_pos [TABLE_DEPTH];
    int     gen_n       = 1;
    longint last_target = 0;

    function automatic bit nearest_lookup(input rcnl_in_t it, output rcnl_out_t res);
        longint pos, pick, sum, d_prev, d_cur;
        int     cnt;
        res = '0;
        case (it.mode)
            MODE_LOAD: begin
                tbl_pos[it.entry_index] = it.entry_position;
                tbl_val[it.entry_index] = it.entry_value;
                return 1'b0;
            end
            MODE_SEAM_START: begin
                cnt = int'(it.entry_count);
                if (cnt > TABLE_DEPTH) cnt = TABLE_DEPTH;
                armed_count = cnt;
                curve_live  = (cnt != 0);
                cursor_idx  = 0;
                prev_idx    = 0;
                return 1'b0;
            end
            MODE_SEAM_END: begin
                curve_live = 1'b0;
                return 1'b0;
            end
            default: ;
        endcase
        if (!curve_live) return 1'b1;

        pos = longint'($signed(it.frame_position)) + longint'(pos_offset);
        if (prev_idx >= armed_count || cursor_idx > armed_count) begin
            cursor_idx = 0;
            prev_idx   = 0;
        end
        // backward jump: rewalk from the start
        if (pos < longint'(tbl_pos[prev_idx])) begin
            cursor_idx = 0;
            prev_idx   = 0;
        end
        pick = tbl_val[armed_count-1];
        while (cursor_idx < armed_count) begin
            if (longint'(tbl_pos[cursor_idx]) > pos) begin
                d_prev = pos - longint'(tbl_pos[prev_idx]);
                d_cur  = pos - longint'(tbl_pos[cursor_idx]);
                if (d_prev < 0) d_prev = -d_prev;
                if (d_cur < 0) d_cur = -d_cur;
                // tie goes to the later entry
                pick = (d_prev < d_cur) ? longint'(tbl_val[prev_idx])
                                        : longint'(tbl_val[cursor_idx]);
                break;
            end
            prev_idx = cursor_idx;
            cursor_idx++;
        end
        sum = pick + longint'(val_offset);
        if (sum > P_MAX) sum = P_MAX;
        if (sum < P_MIN) sum = P_MIN;
        res.ref_value = sum[31:0];
        res.rank_max  = 1'b1;
        return 1'b1;
    endfunction

    // all fields random, so unused ones carry noise
    function automatic rcnl_in_t scrambled(mode_t m);
        rcnl_in_t it;
        it.mode           = m;
        it.entry_index    = IN_INDEX_W'($urandom());
        it.entry_position = $urandom();
        it.entry_value    = $urandom();
        it.entry_count    = IN_COUNT_W'($urandom());
        it.frame_position = $urandom();
        return it;
    endfunction

    function automatic void push_item(rcnl_in_t it);
        stream_items.push_back(it);
        item_total++;
    endfunction

    function automatic void send_load(int idx, logic [31:0] p, logic [31:0] v);
        rcnl_in_t it;
        it = scrambled(MODE_LOAD);
        it.entry_index    = idx[IN_INDEX_W-1:0];
        it.entry_position = p;
        it.entry_value    = v;
        push_item(it);
    endfunction

    function automatic void send_seam(int cnt);
        rcnl_in_t it;
        it = scrambled(MODE_SEAM_START);
        it.entry_count = cnt[IN_COUNT_W-1:0];
        push_item(it);
    endfunction

    function automatic void send_sample(logic [31:0] f);
        rcnl_in_t it;
        it = scrambled(MODE_SAMPLE);
        it.frame_position = f;
        push_item(it);
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_offset();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return $urandom_range(0, 2000) - 32'd1000;
            default: return $urandom();
        endcase
    endfunction

    // aim a sample at the curve: forward walks, some ties, hits, jumps
    function automatic logic [31:0] pick_frame();
        longint target, span, lo, hi, f;
        int     r, i;
        r    = $urandom_range(0, 99);
        i    = $urandom_range(0, gen_n - 1);
        span = (gen_pos[gen_n-1] - gen_pos[0]) / gen_n + 2;
        if (r >= 93) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        if (r >= 86) return $urandom();
        if (r < 40) begin
            target = last_target + longint'($urandom_range(0, 3)) * span / 2;
        end else if (r < 55 && i + 1 < gen_n) begin
            lo = gen_pos[i];
            hi = gen_pos[i+1];
            target = $urandom_range(0, 1) ? lo + (hi - lo) / 2
                                          : lo + longint'($urandom) % (hi - lo + 1);
        end else if (r < 65) begin
            target = gen_pos[i];
        end else if (r < 72) begin
            target = gen_pos[0] - longint'($urandom_range(1, 1000));
        end else if (r < 79) begin
            target = gen_pos[gen_n-1] + longint'($urandom_range(0, 1000));
        end else begin
            target = last_target - longint'($urandom_range(1, 3)) * span;
        end
        last_target = target;
        f = target - longint'(pos_offset);
        if (f > P_MAX) f = P_MAX;
        if (f < P_MIN) f = P_MIN;
        return f[31:0];
    endfunction

    task automatic wait_idle(int settle);
        while (stream_items.size() != 0 || s_tvalid || lookup_results_due.size() != 0)
            @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic apb_write(logic reg_sel, logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (reg_sel == REG_POSITION_OFFSET) pos_offset = data;
        else val_offset = data;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic flag_result(string note, rcnl_out_t want);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s at cycle %0d: ref_value %h rank_max %b, expected %h %b",
                     note, cycle_count, m_tdata, m_tuser[0], want.ref_value, want.rank_max);
    endtask

    // sender: bursts of random length, random gaps after each burst
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || accept_count != seen_count) begin
            seen_count = accept_count;
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (stream_items.size() > 0) begin
                cur_item = stream_items.pop_front();
                s_tdata  <= {3'b000, cur_item.frame_position, cur_item.entry_count,
                             cur_item.entry_value, cur_item.entry_position,
                             cur_item.entry_index};
                s_tuser  <= cur_item.mode;
                s_tvalid <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random ready style, redrawn when its run ends
    int         stall_style = 0;
    int         stall_left  = 0;
    logic [7:0] ready_pattern = 8'hFF;
    logic [2:0] pattern_pos   = '0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_style   = $urandom_range(0, 3);
                stall_left    = $urandom_range(50, 300);
                ready_pattern = 8'($urandom()) | 8'h01;
            end
            stall_left--;
            pattern_pos++;
            case (stall_style)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ready_pattern[pattern_pos];
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // monitor: check results, then predict for the transaction accepted at this edge
    always @(posedge aclk) begin
        rcnl_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (lookup_results_due.size() == 0) begin
                want = '0;
                flag_result("unexpected result", want);
            end else begin
                want = lookup_results_due.pop_front();
                if (m_tdata !== want.ref_value || m_tuser[0] !== want.rank_max)
                    flag_result("mismatch", want);
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            accept_count++;
            if (nearest_lookup(cur_item, want)) lookup_results_due.push_back(want);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int          phase, n_entries, cnt, k, idx, n_samples, s;
        bit          wide, full, desc;
        longint      total, range_w, base;
        mode_t       m;
        rcnl_in_t    it;
        logic [31:0] po, vo;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: no curve, zero count, extreme entries, tie, backward jump, past end
        send_sample($urandom());
        send_seam(0);
        send_sample($urandom());
        send_load(0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_load(1, -32'sd100, 32'd1);
        send_load(2, 32'd100, 32'hFFFF_FFFF);
        send_load(3, 32'h7FFF_FFFF, 32'h8000_0000);
        send_load(TABLE_DEPTH - 1, $urandom(), $urandom());
        send_seam(4);
        send_sample(32'h8000_0000);
        send_sample(32'd0);
        send_sample(32'd50);
        send_sample(-32'sd60);
        send_sample(-32'sd200);
        send_sample(32'h7FFF_FFFF);
        it = scrambled(MODE_SEAM_END);
        push_item(it);
        send_sample($urandom());

        phase = 0;
        while (item_total < ITEM_TARGET) begin
            wait_idle(40);
            po = (phase == 0) ? 32'h7FFF_FFFF : (phase == 1) ? 32'h8000_0000 : pick_offset();
            vo = (phase == 0) ? 32'h7FFF_FFFF : (phase == 1) ? 32'h8000_0000 : pick_offset();
            apb_write(REG_POSITION_OFFSET, po);
            apb_write(REG_VALUE_OFFSET, vo);

            full      = (phase == 3);
            wide      = (phase == 2) || ($urandom_range(0, 5) == 0);
            n_entries = full ? TABLE_DEPTH : $urandom_range(1, 16);
            s         = full ? 16 : $urandom_range(0, 22);

            // strictly ascending positions
            gen_pos[0] = 0;
            for (k = 1; k < n_entries; k++)
                gen_pos[k] = gen_pos[k-1] + 1 + (longint'($urandom) & ((longint'(1) << s) - 1));
            total   = gen_pos[n_entries-1];
            range_w = P_MAX - total - P_MIN + 1;
            base    = wide ? P_MIN : P_MIN + longint'($urandom) % range_w;
            for (k = 0; k < n_entries; k++) gen_pos[k] += base;
            if (wide && n_entries >= 2) gen_pos[n_entries-1] = P_MAX;

            desc = ($urandom_range(0, 3) == 0);
            for (k = 0; k < n_entries; k++) begin
                idx = desc ? n_entries - 1 - k : k;
                send_load(idx, gen_pos[idx][31:0], pick_value());
            end

            if (full) begin
                cnt = $urandom_range(TABLE_DEPTH, 2047);
            end else begin
                k   = $urandom_range(0, 19);
                cnt = (k == 0) ? 0 : (k < 5) ? $urandom_range(1, n_entries) : n_entries;
            end
            gen_n       = (cnt == 0 || cnt > n_entries) ? n_entries : cnt;
            last_target = gen_pos[0] - 1;
            send_seam(cnt);

            n_samples = full ? 24 : $urandom_range(4, 20);
            for (k = 0; k < n_samples; k++) begin
                if ($urandom_range(0, 15) == 0) begin
                    send_seam(cnt);
                    last_target = gen_pos[0] - 1;
                end
                send_sample(pick_frame());
            end

            it = scrambled(MODE_SEAM_END);
            push_item(it);

            // noise while disarmed; a seam start here only ever arms nothing
            n_samples = $urandom_range(0, 4);
            for (k = 0; k < n_samples; k++) begin
                m  = mode_t'($urandom_range(0, 3));
                it = scrambled(m);
                if (m == MODE_SEAM_START) it.entry_count = '0;
                push_item(it);
            end
            phase++;
        end

        wait_idle(1100);
        if (mismatch_count == 0 && lookup_results_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
